### rtl/core/mi3_pkg.sv
`timescale 1ns / 1ps

package mi3_pkg;

  // Element and intermediate widths
  localparam int N_EL    = 9;   // elements of a 3x3 matrix
  localparam int EL_W    = 32;  // one matrix element, signed fixed point
  localparam int COF_W   = 64;  // exact 2x2 cofactor
  localparam int DSUM_W  = 98;  // exact signed determinant
  localparam int DMAG_W  = 97;  // determinant magnitude
  localparam int QUO_W   = 32;  // quotient bits resolved by the divider
  localparam int FIFO_DEPTH = 2;

  // Request passed from the cofactor front end to the divider back end
  typedef struct packed {
    logic [N_EL-1:0][COF_W-1:0] adj;   // adjugate, row-major, signed
    logic [DMAG_W-1:0]          dmag;  // |det|
    logic                       dneg;  // det < 0
    logic                       singular;
  } mi3_item_t;

endpackage

### rtl/core/mi3_front.sv
`timescale 1ns / 1ps

module mi3_front (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          en_i,
  input  logic                                          valid_i,
  input  logic [mi3_pkg::N_EL-1:0][mi3_pkg::EL_W-1:0]   elem_i,
  output logic                                          valid_o,
  output mi3_pkg::mi3_item_t                            item_o
);
  import mi3_pkg::*;

  localparam int NS = 6;

  logic [NS-1:0] v_q;

  logic signed [COF_W-1:0]  pa_q   [N_EL];
  logic signed [COF_W-1:0]  pb_q   [N_EL];
  logic signed [EL_W-1:0]   row1_q [3];
  logic signed [EL_W-1:0]   row2_q [3];
  logic signed [COF_W-1:0]  cof2_q [N_EL];
  logic signed [COF_W-1:0]  cof3_q [N_EL];
  logic signed [COF_W-1:0]  cof4_q [N_EL];
  logic signed [COF_W-1:0]  cof5_q [N_EL];
  logic signed [COF_W-1:0]  cof6_q [N_EL];
  logic signed [COF_W:0]    plo_q  [3];
  logic signed [COF_W-1:0]  phi_q  [3];
  logic signed [COF_W+2:0]  slo_q;
  logic signed [COF_W+1:0]  shi_q;
  logic signed [DSUM_W-1:0] dsum_q;
  logic [DMAG_W-1:0]        dmag_q;
  logic                     dneg_q;
  logic                     sing_q;

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-2:0], valid_i};
    end
  end

  // Stage 1: the two products of every 2x2 minor
  for (genvar gi = 0; gi < 3; gi++) begin : g_row
    for (genvar gj = 0; gj < 3; gj++) begin : g_col
      localparam int R0 = (gi == 0) ? 1 : 0;
      localparam int R1 = (gi == 2) ? 1 : 2;
      localparam int C0 = (gj == 0) ? 1 : 0;
      localparam int C1 = (gj == 2) ? 1 : 2;
      localparam int K  = gi * 3 + gj;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          pa_q[K] <= $signed(elem_i[R0*3+C0]) * $signed(elem_i[R1*3+C1]);
          pb_q[K] <= $signed(elem_i[R0*3+C1]) * $signed(elem_i[R1*3+C0]);
        end
      end
      // Stage 2: signed cofactor
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (((gi + gj) % 2) == 1) begin
            cof2_q[K] <= pb_q[K] - pa_q[K];
          end else begin
            cof2_q[K] <= pa_q[K] - pb_q[K];
          end
        end
      end
    end
  end

  // Row 0 follows the minors into the determinant products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        row1_q[j] <= $signed(elem_i[j]);
        row2_q[j] <= row1_q[j];
      end
    end
  end

  // Stage 3: row 0 times cofactor, with the cofactor split in two 32-bit halves
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        plo_q[j] <= row2_q[j] * $signed({1'b0, cof2_q[j][EL_W-1:0]});
        phi_q[j] <= row2_q[j] * $signed(cof2_q[j][COF_W-1:EL_W]);
      end
      cof3_q <= cof2_q;
    end
  end

  // Stage 4: add the partial products per half
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      slo_q  <= plo_q[0] + plo_q[1] + plo_q[2];
      shi_q  <= phi_q[0] + phi_q[1] + phi_q[2];
      cof4_q <= cof3_q;
    end
  end

  // Stage 5: exact determinant
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dsum_q <= (DSUM_W'(shi_q) <<< EL_W) + DSUM_W'(slo_q);
      cof5_q <= cof4_q;
    end
  end

  // Stage 6: sign, magnitude and zero test
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dneg_q <= dsum_q[DSUM_W-1];
      dmag_q <= DMAG_W'(dsum_q[DSUM_W-1] ? -dsum_q : dsum_q);
      sing_q <= (dsum_q == '0);
      cof6_q <= cof5_q;
    end
  end

  // Adjugate is the transposed cofactor matrix
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        item_o.adj[i*3+j] = cof6_q[j*3+i];
      end
    end
    item_o.dmag     = dmag_q;
    item_o.dneg     = dneg_q;
    item_o.singular = sing_q;
  end

  assign valid_o = v_q[NS-1];

endmodule

### rtl/core/mi3_fifo.sv
`timescale 1ns / 1ps

module mi3_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mi3_pkg::mi3_item_t data_i,
  output logic               ready_o,
  input  logic               pop_i,
  output logic               valid_o,
  output mi3_pkg::mi3_item_t data_o
);
  import mi3_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  mi3_item_t        mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d;
  logic [PTR_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign valid_o = (cnt_q != '0);
  assign ready_o = (cnt_q != CNT_W'(FIFO_DEPTH)) || pop_i;
  assign data_o  = mem_q[rd_q];

  // Pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(FIFO_DEPTH))
    else $error("fifo count above depth");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && !pop_i && (cnt_q == CNT_W'(FIFO_DEPTH))))
    else $error("push into full fifo");
  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != '0))
    else $error("pop from empty fifo");
`endif

endmodule

### rtl/core/mi3_back.sv
`timescale 1ns / 1ps

module mi3_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        valid_i,
  input  mi3_pkg::mi3_item_t                          item_i,
  output logic                                        ready_o,
  output logic                                        valid_o,
  input  logic                                        ready_i,
  output logic [mi3_pkg::N_EL-1:0][mi3_pkg::EL_W-1:0] elem_o,
  output logic [mi3_pkg::EL_W-1:0]                    det_o,
  output logic                                        singular_o,
  output logic                                        overflow_o
);
  import mi3_pkg::*;

  localparam int RW    = DMAG_W + QUO_W + 2;  // remainder width
  localparam int SAT_W = EL_W + 2;
  localparam logic [DMAG_W:0] RND_HALF = (DMAG_W + 1)'(1) << (2 * FRAC_BITS - 1);
  localparam logic [SAT_W-1:0] LIM_POS = SAT_W'(33'h0_7FFF_FFFF);
  localparam logic [SAT_W-1:0] LIM_NEG = SAT_W'(33'h0_8000_0000);

  // Saturate a magnitude with sign; returns {overflow, value}
  function automatic logic [EL_W:0] sat_fn(input logic [SAT_W-1:0] mag, input logic big,
                                           input logic neg);
    logic [SAT_W-1:0] lim;
    logic [SAT_W-1:0] m;
    logic             o;
    lim = neg ? LIM_NEG : LIM_POS;
    o   = big || (mag > lim);
    m   = o ? lim : mag;
    return {o, neg ? -m[EL_W-1:0] : m[EL_W-1:0]};
  endfunction

  logic be;
  assign be      = !valid_o || ready_i;
  assign ready_o = be;

  // Stage A: magnitudes, signs, rounded determinant
  logic                          va_q;
  logic [N_EL-1:0][COF_W-1:0]    amag_q;
  logic [N_EL-1:0]               aneg_q;
  logic [DMAG_W-1:0]             ad_q;
  logic                          adneg_q;
  logic                          asing_q;
  logic [DMAG_W:0]               rd_q;

  always_ff @(posedge clk_i) begin
    if (be) begin
      for (int l = 0; l < N_EL; l++) begin
        amag_q[l] <= item_i.adj[l][COF_W-1] ? -item_i.adj[l] : item_i.adj[l];
        aneg_q[l] <= item_i.adj[l][COF_W-1] ^ item_i.dneg;
      end
      ad_q    <= item_i.dmag;
      adneg_q <= item_i.dneg;
      asing_q <= item_i.singular;
      rd_q    <= {1'b0, item_i.dmag} + RND_HALF;
    end
  end

  // Divider stages; index 0 holds the aligned numerators
  logic [QUO_W:0]                   st_v_q;
  logic [N_EL-1:0][RW-1:0]          st_r_q    [QUO_W+1];
  logic [N_EL-1:0][QUO_W-1:0]       st_qt_q   [QUO_W+1];
  logic [N_EL-1:0]                  st_big_q  [QUO_W+1];
  logic [N_EL-1:0]                  st_neg_q  [QUO_W+1];
  logic [DMAG_W-1:0]                st_d_q    [QUO_W+1];
  logic                             st_sing_q [QUO_W+1];
  logic [EL_W-1:0]                  st_det_q  [QUO_W+1];
  logic                             st_dovf_q [QUO_W+1];

  // Stage B: align numerators, catch quotients beyond 32 bits, saturate det
  logic [N_EL-1:0][RW-1:0] num_b;
  logic [RW-1:0]           dlim_b;
  logic [DMAG_W:0]         rdv_b;
  logic [EL_W:0]           dsat_b;

  always_comb begin
    for (int l = 0; l < N_EL; l++) begin
      num_b[l] = RW'(amag_q[l]) << (2 * FRAC_BITS);
    end
    dlim_b = RW'(ad_q) << QUO_W;
    rdv_b  = rd_q >> (2 * FRAC_BITS);
    dsat_b = sat_fn(rdv_b[SAT_W-1:0], |rdv_b[DMAG_W:SAT_W], adneg_q);
  end

  always_ff @(posedge clk_i) begin
    if (be) begin
      for (int l = 0; l < N_EL; l++) begin
        st_r_q[0][l]   <= num_b[l];
        st_big_q[0][l] <= (num_b[l] >= dlim_b);
      end
      st_qt_q[0]   <= '0;
      st_neg_q[0]  <= aneg_q;
      st_d_q[0]    <= ad_q;
      st_sing_q[0] <= asing_q;
      st_det_q[0]  <= dsat_b[EL_W-1:0];
      st_dovf_q[0] <= dsat_b[EL_W];
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar s = 1; s <= QUO_W; s++) begin : g_div
    localparam int K = QUO_W - s;
    logic [N_EL-1:0][RW:0]      diff;
    logic [N_EL-1:0][QUO_W-1:0] qn;

    always_comb begin
      for (int l = 0; l < N_EL; l++) begin
        diff[l]    = {1'b0, st_r_q[s-1][l]} - {1'b0, RW'(st_d_q[s-1]) << K};
        qn[l]      = st_qt_q[s-1][l];
        qn[l][K]   = !diff[l][RW];
      end
    end

    always_ff @(posedge clk_i) begin
      if (be) begin
        for (int l = 0; l < N_EL; l++) begin
          st_r_q[s][l] <= diff[l][RW] ? st_r_q[s-1][l] : diff[l][RW-1:0];
        end
        st_qt_q[s]   <= qn;
        st_big_q[s]  <= st_big_q[s-1];
        st_neg_q[s]  <= st_neg_q[s-1];
        st_d_q[s]    <= st_d_q[s-1];
        st_sing_q[s] <= st_sing_q[s-1];
        st_det_q[s]  <= st_det_q[s-1];
        st_dovf_q[s] <= st_dovf_q[s-1];
      end
    end
  end

  // Round half away from zero
  logic                       rv_q;
  logic [N_EL-1:0][QUO_W:0]   rq_q;
  logic [N_EL-1:0]            rbig_q;
  logic [N_EL-1:0]            rneg_q;
  logic                       rsing_q;
  logic [EL_W-1:0]            rdet_q;
  logic                       rdovf_q;

  always_ff @(posedge clk_i) begin
    if (be) begin
      for (int l = 0; l < N_EL; l++) begin
        rq_q[l] <= {1'b0, st_qt_q[QUO_W][l]} +
                   (QUO_W + 1)'({st_r_q[QUO_W][l], 1'b0} >= {2'b0, RW'(st_d_q[QUO_W])} >> 1 << 1
                                ? ({st_r_q[QUO_W][l], 1'b0} >= {1'b0, RW'(st_d_q[QUO_W])})
                                : 1'b0);
      end
      rbig_q  <= st_big_q[QUO_W];
      rneg_q  <= st_neg_q[QUO_W];
      rsing_q <= st_sing_q[QUO_W];
      rdet_q  <= st_det_q[QUO_W];
      rdovf_q <= st_dovf_q[QUO_W];
    end
  end

  // Saturate, apply sign, flush singular results
  logic [N_EL-1:0][EL_W:0] lsat;
  logic [N_EL-1:0]         lovf;

  always_comb begin
    for (int l = 0; l < N_EL; l++) begin
      lsat[l] = sat_fn({1'b0, rq_q[l]}, rbig_q[l],
                       rneg_q[l] && ((rq_q[l] != '0) || rbig_q[l]));
      lovf[l] = lsat[l][EL_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (be) begin
      for (int l = 0; l < N_EL; l++) begin
        elem_o[l] <= rsing_q ? '0 : lsat[l][EL_W-1:0];
      end
      det_o      <= rsing_q ? '0 : rdet_q;
      singular_o <= rsing_q;
      overflow_o <= !rsing_q && (rdovf_q || (|lovf));
    end
  end

  // Valid bits of the whole back pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      st_v_q  <= '0;
      rv_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (be) begin
      va_q    <= valid_i;
      st_v_q  <= {st_v_q[QUO_W-1:0], va_q};
      rv_q    <= st_v_q[QUO_W];
      valid_o <= rv_q;
    end
  end

endmodule

### rtl/core/matrix_inverse_3x3_unit.sv
`timescale 1ns / 1ps
// Channel  Dir  tdata                                 tuser
// s_axis   in   in_r0_c0 .. in_r2_c2 (9 x 32, 288b)   -
// m_axis   out  out_r0_c0 .. out_r2_c2, det_value     singular, overflow
//
// If m_axis is ready, one matrix per cycle goes in and one result per cycle out.
// The path runs through 6 cofactor/determinant stages, 1 queue slot and
// 36 back stages, of which 32 are the restoring divider (one quotient bit each).
// Reset clears only valid bits and queue pointers; there is no state between items.
// A stall on m_axis freezes the back end; the front keeps accepting until the
// two-entry queue fills, then s_axis_tready_o drops.

module matrix_inverse_3x3_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [287:0] s_axis_tdata_i,  // in_r0_c0, in_r0_c1, ..., in_r2_c2
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [319:0] m_axis_tdata_o,  // out_r0_c0, ..., out_r2_c2, det_value
  output logic [1:0]   m_axis_tuser_o   // singular, overflow
);
  import mi3_pkg::*;

  logic [N_EL-1:0][EL_W-1:0] elem;
  logic                      fe_en;
  logic                      fe_valid;
  mi3_item_t                 fe_item;
  logic                      q_ready;
  logic                      q_valid;
  mi3_item_t                 q_item;
  logic                      be_ready;
  logic [N_EL-1:0][EL_W-1:0] res_elem;
  logic [EL_W-1:0]           res_det;
  logic                      res_sing;
  logic                      res_ovf;

  // Unpack matrix elements
  always_comb begin
    for (int k = 0; k < N_EL; k++) begin
      elem[k] = s_axis_tdata_i[k*EL_W +: EL_W];
    end
  end

  assign fe_en           = q_ready;
  assign s_axis_tready_o = fe_en;

  mi3_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (fe_en),
    .valid_i (s_axis_tvalid_i),
    .elem_i  (elem),
    .valid_o (fe_valid),
    .item_o  (fe_item)
  );

  mi3_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_valid && fe_en),
    .data_i  (fe_item),
    .ready_o (q_ready),
    .pop_i   (q_valid && be_ready),
    .valid_o (q_valid),
    .data_o  (q_item)
  );

  mi3_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (q_valid),
    .item_i     (q_item),
    .ready_o    (be_ready),
    .valid_o    (m_axis_tvalid_o),
    .ready_i    (m_axis_tready_i),
    .elem_o     (res_elem),
    .det_o      (res_det),
    .singular_o (res_sing),
    .overflow_o (res_ovf)
  );

  assign m_axis_tdata_o = {res_det, res_elem};
  assign m_axis_tuser_o = {res_ovf, res_sing};

`ifndef SYNTHESIS
  logic sat_seen;
  always_comb begin
    sat_seen = 1'b0;
    for (int k = 0; k <= N_EL; k++) begin
      if ((m_axis_tdata_o[k*EL_W +: EL_W] == 32'h7FFF_FFFF) ||
          (m_axis_tdata_o[k*EL_W +: EL_W] == 32'h8000_0000)) begin
        sat_seen = 1'b1;
      end
    end
  end

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (m_axis_tdata_o == '0) && !m_axis_tuser_o[1])
    else $error("singular result not flushed");
  a_ovf_has_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |-> sat_seen)
    else $error("overflow without saturated field");
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without output backpressure");
`endif

endmodule

### dv/mi3_checker.sv
`timescale 1ns / 1ps

// Watches both streams, predicts each inverse from the accepted matrix and
// compares the oldest prediction with every delivered result.
module mi3_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  input  logic         s_axis_tready_i,
  input  logic [287:0] s_axis_tdata_i,
  input  logic         m_axis_tvalid_i,
  input  logic         m_axis_tready_i,
  input  logic [319:0] m_axis_tdata_i,
  input  logic [1:0]   m_axis_tuser_i,
  output int           errors_o,
  output int           pending_o
);
  import mi3_pkg::*;

  typedef struct packed {
    logic               ovf;
    logic               sing;
    logic [9:0][31:0]   val;  // inverse row-major, then determinant
  } inv_result_t;

  inv_result_t inv_q[$];

  function automatic inv_result_t predict_inverse(logic [287:0] d);
    logic signed [65:0]  x [9];
    logic signed [65:0]  cof [3][3];
    logic signed [131:0] dsum;
    logic [127:0]        dmag, rd, num, q, r, lim;
    logic                dneg, neg;
    logic signed [65:0]  adj;
    logic [65:0]         amag;
    inv_result_t         res;
    int                  r0, r1, c0, c1;
    for (int k = 0; k < 9; k++) x[k] = $signed(d[k*32 +: 32]);
    for (int i = 0; i < 3; i++) begin
      r0 = (i == 0) ? 1 : 0;
      r1 = (i == 2) ? 1 : 2;
      for (int j = 0; j < 3; j++) begin
        c0 = (j == 0) ? 1 : 0;
        c1 = (j == 2) ? 1 : 2;
        cof[i][j] = x[r0*3+c0] * x[r1*3+c1] - x[r0*3+c1] * x[r1*3+c0];
        if ((i + j) % 2 == 1) cof[i][j] = -cof[i][j];
      end
    end
    dsum = 0;
    for (int j = 0; j < 3; j++) dsum = dsum + x[j] * cof[0][j];
    dneg = dsum < 0;
    dmag = dneg ? 128'(-dsum) : 128'(dsum);
    res = '0;
    // singular matrix: all zero, flag only
    if (dmag == 0) begin
      res.sing = 1'b1;
      return res;
    end
    rd = (dmag + (128'd1 << (2*FRAC_BITS - 1))) >> (2*FRAC_BITS);
    lim = dneg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (rd > lim) begin
      rd = lim;
      res.ovf = 1'b1;
    end
    res.val[9] = dneg ? (32'd0 - rd[31:0]) : rd[31:0];
    // inverse element (i,j) = cof(j,i) / det, rounded half away from zero
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        adj  = cof[j][i];
        amag = (adj < 0) ? 66'(-adj) : 66'(adj);
        num  = 128'(amag) << (2*FRAC_BITS);
        q    = num / dmag;
        r    = num % dmag;
        if ((r << 1) >= dmag) q = q + 1;
        neg = ((adj < 0) != dneg) && (q != 0);
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > lim) begin
          q = lim;
          res.ovf = 1'b1;
        end
        res.val[i*3+j] = neg ? (32'd0 - q[31:0]) : q[31:0];
      end
    return res;
  endfunction

  assign pending_o = inv_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    inv_result_t want, got;
    if (!rst_ni) begin
      errors_o <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) inv_q.push_back(predict_inverse(s_axis_tdata_i));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.val  = m_axis_tdata_i;
        got.sing = m_axis_tuser_i[0];
        got.ovf  = m_axis_tuser_i[1];
        if (inv_q.size() == 0) begin
          if (errors_o < 10) $display("ERROR: result with no request outstanding");
          errors_o <= errors_o + 1;
        end else begin
          want = inv_q.pop_front();
          if (want != got) begin
            if (errors_o < 10) begin
              $display("ERROR: mismatch at %0t", $realtime);
              for (int k = 0; k < 10; k++)
                if (want.val[k] != got.val[k])
                  $display("  field %0d exp %h got %h", k, want.val[k], got.val[k]);
              $display("  singular exp %b got %b, overflow exp %b got %b",
                       want.sing, got.sing, want.ovf, got.ovf);
            end
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end
endmodule

### dv/tb_matrix_inverse_3x3_unit.sv
`timescale 1ns / 1ps

module tb_matrix_inverse_3x3_unit;
  localparam int NUM_RANDOM = 1000;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [287:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [319:0] m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;
  int           errors, pending;
  int           sent = 0;
  int           quiet = 0;
  logic         calm = 1'b0;   // stretch with no idling on either side

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  matrix_inverse_3x3_unit dut (.*);

  mi3_checker chk (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i, .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i,
    .m_axis_tdata_i(m_axis_tdata_o), .m_axis_tuser_i(m_axis_tuser_o),
    .errors_o(errors), .pending_o(pending)
  );

  // receiver: random back-pressure plus one long hold-off
  initial begin
    int hold_left;
    logic held;
    held = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (!held && sent >= 300) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= calm || ($urandom_range(99) >= 37);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_matrix(logic [287:0] m);
    @(negedge clk_i);
    if (!calm && $urandom_range(99) < 37) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(2, 1)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= m;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sent++;
  endtask

  function automatic logic [287:0] diag(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    logic [287:0] m;
    m = '0;
    m[0*32 +: 32] = a;
    m[4*32 +: 32] = b;
    m[8*32 +: 32] = c;
    return m;
  endfunction

  function automatic logic [287:0] rand_matrix();
    logic [287:0] m;
    int kind;
    kind = $urandom_range(9);
    for (int k = 0; k < 9; k++) begin
      if (kind < 3) m[k*32 +: 32] = $urandom();
      else if (kind < 8) m[k*32 +: 32] = 32'($signed($urandom_range(524287)) - 262144);
      else m[k*32 +: 32] = 32'($signed($urandom_range(8191)) - 4096) <<< 4;
    end
    // singular: repeat a row or a column
    if (kind == 9) m[3*32 +: 96] = m[0 +: 96];
    if (kind == 8 && $urandom_range(1))
      for (int r = 0; r < 3; r++) m[(r*3+2)*32 +: 32] = m[(r*3)*32 +: 32];
    return m;
  endfunction

  initial begin
    logic [287:0] m;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed matrices
    send_matrix('0);
    send_matrix(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    send_matrix(diag(32'hFFFF_0000, 32'h0002_0000, 32'h0000_8000));
    send_matrix(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_matrix(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_matrix(diag(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send_matrix(diag(32'd1, 32'd1, 32'd1));            // tiny determinant
    send_matrix(diag(32'h0000_0100, 32'h0001_0000, 32'h0001_0000));
    send_matrix(diag(32'h0000_0003, 32'h0000_0003, 32'h0000_0003));
    send_matrix('1);                                   // all minus one lsb
    send_matrix({9{32'h7FFF_FFFF}});
    send_matrix({9{32'h8000_0000}});
    send_matrix({9{32'h5555_5555}} ^ {32'hFFFF_FFFF, 256'h0});
    send_matrix({32'h0003_0000, 32'h0001_0000, 32'h0000_0000,
                 32'hFFFE_0000, 32'h0000_8000, 32'h0002_0000,
                 32'h0001_0000, 32'h0004_0000, 32'hFFFF_8000});
    send_matrix({32'h0000_0000, 32'h0001_0000, 32'h0000_0000,
                 32'h0000_0000, 32'h0000_0000, 32'h0001_0000,
                 32'h0001_0000, 32'h0000_0000, 32'h0000_0000});

    for (int n = 0; n < NUM_RANDOM; n++) begin
      calm = (n >= 500 && n < 650);
      // wait for the pipe to drain once mid-run
      if (n == 700) begin
        @(negedge clk_i);
        s_axis_tvalid_i <= 1'b0;
        wait (pending == 0);
      end
      m = rand_matrix();
      send_matrix(m);
    end
    calm = 1'b0;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;

    wait (pending == 0);
    repeat (60) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

### files.f
rtl/core/mi3_pkg.sv
rtl/core/mi3_front.sv
rtl/core/mi3_fifo.sv
rtl/core/mi3_back.sv
rtl/core/matrix_inverse_3x3_unit.sv
dv/mi3_checker.sv
dv/tb_matrix_inverse_3x3_unit.sv
